[src/tgfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgfr_pkg
// Shared types and constants for the tiled grid flip and rotate block.
// ----------------------------------------------------------------------------
package tgfr_pkg;

    localparam int MAX_LOG_SIDE = 6;
    localparam int VALUE_BITS   = 32;
    localparam int POS_BITS     = MAX_LOG_SIDE;
    localparam int CELL_BITS    = 2 * MAX_LOG_SIDE;
    localparam int ADDR_BITS    = CELL_BITS + 1;
    localparam int LOG_BITS     = 3;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_APPLY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_OP  = 2'd1;
    localparam logic [1:0] ST_BAD_LVL = 2'd2;
    localparam logic [1:0] ST_OUTSIDE = 2'd3;

    typedef enum logic [1:0] {
        JOB_WRITE,
        JOB_READ,
        JOB_APPLY,
        JOB_REPLY
    } job_kind_t;

    typedef struct packed {
        job_kind_t               kind;
        logic [POS_BITS-1:0]     row;
        logic [POS_BITS-1:0]     col;
        logic [VALUE_BITS-1:0]   value;
        logic [3:0]              op_code;
        logic [LOG_BITS-1:0]     level;
        logic [LOG_BITS-1:0]     lg;
        logic [1:0]              status;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_COPY,
        BK_WAIT,
        BK_OUT
    } back_state_t;

endpackage
`default_nettype wire

[src/tgfr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgfr_front
// Accepts requests, checks them against the side in use and queues jobs.
// ----------------------------------------------------------------------------
module tgfr_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   cmd,
    input  wire logic [tgfr_pkg::POS_BITS-1:0] row,
    input  wire logic [tgfr_pkg::POS_BITS-1:0] col,
    input  wire logic [tgfr_pkg::VALUE_BITS-1:0] cell_value,
    input  wire logic [3:0]                   op_code,
    input  wire logic [2:0]                   level,
    input  wire logic [2:0]                   log_side,
    output logic                              job_valid,
    input  wire logic                         job_ready,
    output tgfr_pkg::job_t                    job
);
    import tgfr_pkg::*;

    job_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    job_t       j;
    logic [LOG_BITS-1:0] lg;
    logic       outside;
    logic       push, pop;

    always_comb
    begin
        lg = (log_side > LOG_BITS'(MAX_LOG_SIDE)) ? LOG_BITS'(MAX_LOG_SIDE) : log_side;
        outside = ((row >> lg) != '0) || ((col >> lg) != '0);
        j.row = row;
        j.col = col;
        j.value = cell_value;
        j.op_code = op_code;
        j.level = level;
        j.lg = lg;
        j.status = ST_OK;
        j.kind = JOB_REPLY;
        case (cmd)
            CMD_WRITE, CMD_READ:
            begin
                if (outside)
                    j.status = ST_OUTSIDE;
                else
                    j.kind = (cmd == CMD_WRITE) ? JOB_WRITE : JOB_READ;
            end
            CMD_APPLY:
            begin
                if (op_code < 4'd1 || op_code > 4'd8)
                    j.status = ST_BAD_OP;
                else if (level > lg)
                    j.status = ST_BAD_LVL;
                else
                    j.kind = JOB_APPLY;
            end
            default: j.status = ST_BAD_OP;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wp_reg] <= j;
    end

endmodule
`default_nettype wire

[src/tgfr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tgfr_back
// Carries out queued jobs on the two-bank grid store and holds the reply.
// ----------------------------------------------------------------------------
module tgfr_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_valid,
    output logic                                job_ready,
    input  tgfr_pkg::job_t                      job,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tgfr_pkg::VALUE_BITS-1:0]     read_value,
    output logic [1:0]                          status
);
    import tgfr_pkg::*;

    localparam int STRIDE = 1 << MAX_LOG_SIDE;

    logic [VALUE_BITS-1:0] mem [2 * STRIDE * STRIDE];

    back_state_t state_reg, state_next;
    logic        bank_reg, bank_next;
    logic [CELL_BITS-1:0] idx_reg, idx_next;
    logic [VALUE_BITS-1:0] rv_reg, rv_next;
    logic [1:0]  st_reg, st_next;
    logic        read_pend_reg, read_pend_next;
    logic        wr_pend_reg, wr_pend_next;
    logic [ADDR_BITS-1:0] wa_reg, wa_next;
    logic [VALUE_BITS-1:0] rdata_reg;
    job_t        cur_reg, cur_next;

    logic                 rd_en, wr_en;
    logic [ADDR_BITS-1:0] rd_addr, wr_addr;
    logic [VALUE_BITS-1:0] wr_data;
    logic [POS_BITS-1:0]  r, c, x, y, tm, ti, tj, mm, si, sj, sx, sy, sr, sc;
    logic                 in_grid;

    // Source position for the destination cell at the copy index.
    always_comb
    begin
        r  = idx_reg[CELL_BITS-1:POS_BITS];
        c  = idx_reg[POS_BITS-1:0];
        tm = POS_BITS'((7'd1 << cur_reg.level) - 7'd1);
        mm = POS_BITS'((7'd1 << (cur_reg.lg - cur_reg.level)) - 7'd1);
        ti = r >> cur_reg.level;
        tj = c >> cur_reg.level;
        x  = r & tm;
        y  = c & tm;
        si = ti; sj = tj; sx = x; sy = y;
        case (cur_reg.op_code)
            4'd1: sx = tm - x;
            4'd2: sy = tm - y;
            4'd3: begin sx = tm - y; sy = x; end
            4'd4: begin sx = y; sy = tm - x; end
            4'd5: si = mm - ti;
            4'd6: sj = mm - tj;
            4'd7: begin si = mm - tj; sj = ti; end
            default: begin si = tj; sj = mm - ti; end
        endcase
        in_grid = ((r >> cur_reg.lg) == '0) && ((c >> cur_reg.lg) == '0);
        sr = in_grid ? ((si << cur_reg.level) | sx) : r;
        sc = in_grid ? ((sj << cur_reg.level) | sy) : c;
    end

    always_comb
    begin
        state_next     = state_reg;
        bank_next      = bank_reg;
        idx_next       = idx_reg;
        rv_next        = rv_reg;
        st_next        = st_reg;
        cur_next       = cur_reg;
        read_pend_next = 1'b0;
        wr_pend_next   = 1'b0;
        wa_next        = wa_reg;
        job_ready      = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = {bank_reg, sr, sc};
        wr_en          = wr_pend_reg;
        wr_addr        = wa_reg;
        wr_data        = rdata_reg;
        if (read_pend_reg)
            rv_next = rdata_reg;
        case (state_reg)
            BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    cur_next = job;
                    rv_next  = '0;
                    st_next  = job.status;
                    case (job.kind)
                        JOB_WRITE:
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = {bank_reg, job.row, job.col};
                            wr_data    = job.value;
                            state_next = BK_OUT;
                        end
                        JOB_READ:
                        begin
                            rd_en          = 1'b1;
                            rd_addr        = {bank_reg, job.row, job.col};
                            read_pend_next = 1'b1;
                            state_next     = BK_WAIT;
                        end
                        JOB_APPLY:
                        begin
                            idx_next   = '0;
                            state_next = BK_COPY;
                        end
                        default: state_next = BK_OUT;
                    endcase
                end
            end
            BK_COPY:
            begin
                rd_en        = 1'b1;
                wr_pend_next = 1'b1;
                wa_next      = {~bank_reg, idx_reg};
                idx_next     = idx_reg + CELL_BITS'(1);
                if (idx_reg == '1)
                begin
                    state_next = BK_WAIT;
                end
            end
            BK_WAIT:
            begin
                if (cur_reg.kind == JOB_APPLY)
                    bank_next = ~bank_reg;
                state_next = BK_OUT;
            end
            BK_OUT:
            begin
                if (out_ready)
                    state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    assign out_valid  = (state_reg == BK_OUT);
    assign read_value = rv_reg;
    assign status     = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            bank_reg      <= 1'b0;
            read_pend_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_reg      <= bank_next;
            read_pend_reg <= read_pend_next;
            wr_pend_reg   <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        rv_reg  <= rv_next;
        st_reg  <= st_next;
        cur_reg <= cur_next;
        wa_reg  <= wa_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_addr];
    end

endmodule
`default_nettype wire

[src/tiled_grid_flip_rotate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tiled_grid_flip_rotate
// Square grid store with tile-wise flips and quarter turns.
// ----------------------------------------------------------------------------
// A write request is answered once its job leaves the queue and the write is
// made; a read request also passes through the wait state, as the grid memory
// has a registered read. An apply request copies all 4096 cells of the 64 by
// 64 bank into the other bank through the single read port of the grid memory,
// one cell a cycle, before its reply is given. A two-entry queue decouples the
// front from the back, so requests may arrive while a reply waits to be taken.
module tiled_grid_flip_rotate (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // cmd[1:0], row[7:2], col[13:8], cell_value[45:14], op_code[49:46],
    // level[52:50], zero fill to 56 bits.
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_value[31:0], status[33:32], zero fill to 40 bits.
    output logic [39:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_wdata
);
    import tgfr_pkg::*;

    logic [2:0] log_side_reg;
    logic       job_valid, job_ready;
    job_t       job;
    logic [VALUE_BITS-1:0] rv;
    logic [1:0] st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            log_side_reg <= 3'd6;
        else if (cfg_we)
            log_side_reg <= cfg_wdata;
    end

    tgfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cmd        (s_tdata[1:0]),
        .row        (s_tdata[7:2]),
        .col        (s_tdata[13:8]),
        .cell_value (s_tdata[45:14]),
        .op_code    (s_tdata[49:46]),
        .level      (s_tdata[52:50]),
        .log_side   (log_side_reg),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    tgfr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .read_value (rv),
        .status     (st)
    );

    assign m_tdata = {6'd0, st, rv};

endmodule
`default_nettype wire
